FILE: rtl/ppsh_pkg.sv
`timescale 1ns / 1ps
package ppsh_pkg;

   localparam int COORD_WIDTH_DEF  = 16;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int ANGLE_TABLE_LEN  = 24;
   localparam int CORD_GUARD       = 20;
   localparam int ANGLE_FRAC       = 16;
   localparam int Z_W              = 32;
   localparam int GAIN_W           = 30;
   localparam int RANGE_SHIFT      = 46;
   localparam int CHUNK_W          = 16;

   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 88;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_ADDR_W-1:0] REG_DISTANCE_GAIN      = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_APPROACH_RATE_GAIN = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_SPEED_CEILING      = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_SMOOTHING_CONSTANT = 2'd3;

   localparam logic [23:0] DISTANCE_GAIN_RST      = 24'd8389;
   localparam logic [23:0] APPROACH_RATE_GAIN_RST = 24'd13422;
   localparam logic [14:0] SPEED_CEILING_RST      = 15'd13107;
   localparam logic [23:0] SMOOTHING_CONSTANT_RST = 24'd3355;

   localparam logic [GAIN_W-1:0] CORDIC_GAIN_Q30 = 30'd652032874;
   localparam logic [RANGE_SHIFT:0] RANGE_ROUND  = 47'd1 << (RANGE_SHIFT - 1);
   localparam logic signed [Z_W-1:0] HALF_TURN_Q16 = 32'sd1179648000;
   localparam logic [15:0] FULL_TURN = 16'd36000;

   // atan(2^-i) in centidegrees, q16
   localparam logic signed [Z_W-1:0] ATAN_Q16 [ANGLE_TABLE_LEN] = '{
      32'sd294912000, 32'sd174096719, 32'sd91987925, 32'sd46694507,
      32'sd23437865,  32'sd11730358,  32'sd5866610,  32'sd2933484,
      32'sd1466765,   32'sd733385,    32'sd366693,   32'sd183347,
      32'sd91674,     32'sd45837,     32'sd22918,    32'sd11459,
      32'sd5730,      32'sd2865,      32'sd1432,     32'sd716,
      32'sd358,       32'sd179,       32'sd90,       32'sd45
   };

   typedef struct packed {
      logic [23:0] distance_gain;
      logic [23:0] approach_rate_gain;
      logic [14:0] speed_ceiling;
   } cfg_type;

   typedef struct packed {
      logic [15:0] drive_speed;
      logic [15:0] travel_angle;
      logic [15:0] range_to_goal;
   } res_type;

   // reduce an angle in -131072..131071 into 0..35999
   function automatic logic [15:0] wrap_turn(input logic signed [18:0] v);
      logic signed [18:0] base;
      logic signed [18:0] r;
      base = -19'sd144000;
      for (int k = 1; k < 8; k++) begin
         if (v >= 19'(k * 36000 - 144000)) begin
            base = 19'(k * 36000 - 144000);
         end
      end
      r = v - base;
      return r[15:0];
   endfunction

endpackage

FILE: rtl/ppsh_cell.sv
`timescale 1ns / 1ps
module ppsh_cell #(
   parameter int DATA_W = 36,
   parameter int SHIFT  = 0,
   parameter logic signed [ppsh_pkg::Z_W-1:0] ANGLE = '0
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  logic signed [DATA_W-1:0]         in_a,
   input  logic signed [DATA_W-1:0]         in_b,
   input  logic signed [ppsh_pkg::Z_W-1:0]  in_z,
   output logic                             out_valid,
   output logic signed [DATA_W-1:0]         out_a,
   output logic signed [DATA_W-1:0]         out_b,
   output logic signed [ppsh_pkg::Z_W-1:0]  out_z
);

   logic                            valid_ff;
   logic signed [DATA_W-1:0]        a_ff, a_in;
   logic signed [DATA_W-1:0]        b_ff, b_in;
   logic signed [ppsh_pkg::Z_W-1:0] z_ff, z_in;

   always_comb begin
      if (!in_b[DATA_W-1] && (in_b != '0)) begin
         a_in = in_a + (in_b >>> SHIFT);
         b_in = in_b - (in_a >>> SHIFT);
         z_in = in_z + ANGLE;
      end else begin
         a_in = in_a - (in_b >>> SHIFT);
         b_in = in_b + (in_a >>> SHIFT);
         z_in = in_z - ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      z_ff <= z_in;
   end

   assign out_valid = valid_ff;
   assign out_a     = a_ff;
   assign out_b     = b_ff;
   assign out_z     = z_ff;

endmodule

FILE: rtl/ppsh_cordic.sv
`timescale 1ns / 1ps
module ppsh_cordic #(
   parameter int COORD_WIDTH  = ppsh_pkg::COORD_WIDTH_DEF,
   parameter int CORDIC_STEPS = ppsh_pkg::CORDIC_STEPS_DEF,
   localparam int DATA_W = COORD_WIDTH + ppsh_pkg::CORD_GUARD
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic signed [COORD_WIDTH:0]      dx,
   input  logic signed [COORD_WIDTH:0]      dy,
   output logic                             done,
   output logic signed [DATA_W-1:0]         a_out,
   output logic signed [ppsh_pkg::Z_W-1:0]  z_out
);

   logic                            v0_ff;
   logic signed [DATA_W-1:0]        a0_ff, a0_in, b0_ff, b0_in;
   logic signed [ppsh_pkg::Z_W-1:0] z0_ff, z0_in;
   logic signed [DATA_W-1:0]        a_pre, b_pre;

   logic                            v_chain [CORDIC_STEPS+1];
   logic signed [DATA_W-1:0]        a_chain [CORDIC_STEPS+1];
   logic signed [DATA_W-1:0]        b_chain [CORDIC_STEPS];
   logic signed [ppsh_pkg::Z_W-1:0] z_chain [CORDIC_STEPS+1];

   // lower half plane is turned by half a turn first
   always_comb begin
      a_pre = DATA_W'(dy) <<< ppsh_pkg::ANGLE_FRAC;
      b_pre = DATA_W'(dx) <<< ppsh_pkg::ANGLE_FRAC;
      if (dy[COORD_WIDTH]) begin
         a0_in = -a_pre;
         b0_in = -b_pre;
         z0_in = ppsh_pkg::HALF_TURN_Q16;
      end else begin
         a0_in = a_pre;
         b0_in = b_pre;
         z0_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= start;
      end
      a0_ff <= a0_in;
      b0_ff <= b0_in;
      z0_ff <= z0_in;
   end

   assign v_chain[0] = v0_ff;
   assign a_chain[0] = a0_ff;
   assign b_chain[0] = b0_ff;
   assign z_chain[0] = z0_ff;

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
      if (i < CORDIC_STEPS - 1) begin : g_mid
         ppsh_cell #(
            .DATA_W (DATA_W),
            .SHIFT  (i),
            .ANGLE  (ppsh_pkg::ATAN_Q16[i])
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .in_valid  (v_chain[i]),
            .in_a      (a_chain[i]),
            .in_b      (b_chain[i]),
            .in_z      (z_chain[i]),
            .out_valid (v_chain[i+1]),
            .out_a     (a_chain[i+1]),
            .out_b     (b_chain[i+1]),
            .out_z     (z_chain[i+1])
         );
      end else begin : g_end
         ppsh_cell #(
            .DATA_W (DATA_W),
            .SHIFT  (i),
            .ANGLE  (ppsh_pkg::ATAN_Q16[i])
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .in_valid  (v_chain[i]),
            .in_a      (a_chain[i]),
            .in_b      (b_chain[i]),
            .in_z      (z_chain[i]),
            .out_valid (v_chain[i+1]),
            .out_a     (a_chain[i+1]),
            .out_b     (),
            .out_z     (z_chain[i+1])
         );
      end
   end

   assign done  = v_chain[CORDIC_STEPS];
   assign a_out = a_chain[CORDIC_STEPS];
   assign z_out = z_chain[CORDIC_STEPS];

endmodule

FILE: rtl/ppsh_scale.sv
`timescale 1ns / 1ps
module ppsh_scale #(
   parameter int COORD_WIDTH = ppsh_pkg::COORD_WIDTH_DEF,
   localparam int DATA_W = COORD_WIDTH + ppsh_pkg::CORD_GUARD
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic signed [DATA_W-1:0]         cord_a,
   input  logic signed [ppsh_pkg::Z_W-1:0]  cord_z,
   input  logic                             zero,
   input  logic [15:0]                      heading,
   input  ppsh_pkg::cfg_type                cfg,
   output logic                             res_valid,
   input  logic                             res_take,
   output ppsh_pkg::res_type                res
);

   localparam int NCHUNK = (DATA_W - 1 + ppsh_pkg::CHUNK_W - 1) / ppsh_pkg::CHUNK_W;
   localparam int PAD_W  = NCHUNK * ppsh_pkg::CHUNK_W;
   localparam int ACC_W  = PAD_W + ppsh_pkg::GAIN_W;
   localparam int RNG_W  = ACC_W + 1 - ppsh_pkg::RANGE_SHIFT;
   localparam int CNT_W  = $clog2(NCHUNK);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MUL   = 3'd1;
   localparam logic [2:0] S_RANGE = 3'd2;
   localparam logic [2:0] S_PROD  = 3'd3;
   localparam logic [2:0] S_SUM   = 3'd4;
   localparam logic [2:0] S_HOLD  = 3'd5;

   logic [2:0]              state_ff, state_in;
   logic [PAD_W-1:0]        mag_ff, mag_in;
   logic [ACC_W-1:0]        acc_ff, acc_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [15:0]             bear_ff, bear_in;
   logic [15:0]             range_ff, range_in;
   logic [15:0]             travel_ff, travel_in;
   logic [15:0]             last_ff, last_in;
   logic [39:0]             p1_ff, p1_in;
   logic signed [41:0]      p2_ff, p2_in;
   ppsh_pkg::res_type       res_ff, res_in;

   logic signed [ppsh_pkg::Z_W:0]  z_rnd;
   logic signed [16:0]             z_cd;
   logic [ACC_W-1:0]               prod;
   logic [ACC_W:0]                 rnd;
   logic [RNG_W-1:0]               rng_full;
   logic signed [18:0]             t_diff;
   logic signed [16:0]             r_diff;
   logic signed [24:0]             ag_s;
   logic signed [41:0]             s_sum;
   logic signed [32:0]             spd;

   always_comb begin
      state_in  = state_ff;
      mag_in    = mag_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      bear_in   = bear_ff;
      range_in  = range_ff;
      travel_in = travel_ff;
      last_in   = last_ff;
      p1_in     = p1_ff;
      p2_in     = p2_ff;
      res_in    = res_ff;

      z_rnd    = (ppsh_pkg::Z_W + 1)'(cord_z) + 33'sd32768;
      z_cd     = 17'(z_rnd >>> ppsh_pkg::ANGLE_FRAC);
      prod     = ACC_W'(mag_ff[PAD_W-1 -: ppsh_pkg::CHUNK_W])
               * ACC_W'(ppsh_pkg::CORDIC_GAIN_Q30);
      rnd      = (ACC_W + 1)'(acc_ff) + (ACC_W + 1)'(ppsh_pkg::RANGE_ROUND);
      rng_full = rnd[ACC_W:ppsh_pkg::RANGE_SHIFT];
      t_diff   = $signed({3'b000, bear_ff}) - $signed({3'b000, heading});
      r_diff   = $signed({1'b0, range_ff}) - $signed({1'b0, last_ff});
      ag_s     = $signed({1'b0, cfg.approach_rate_gain});
      s_sum    = $signed({2'b00, p1_ff}) + p2_ff;
      spd      = 33'((s_sum + 42'sd256) >>> 9);

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               mag_in = cord_a[DATA_W-1] ? '0 : PAD_W'(cord_a[DATA_W-2:0]);
               acc_in = '0;
               cnt_in = CNT_W'(NCHUNK - 1);
               if (zero) begin
                  bear_in = '0;
               end else if (z_cd[16]) begin
                  bear_in = 16'(z_cd + 17'sd36000);
               end else begin
                  bear_in = z_cd[15:0];
               end
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            acc_in = (acc_ff << ppsh_pkg::CHUNK_W) + prod;
            mag_in = mag_ff << ppsh_pkg::CHUNK_W;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_RANGE;
            end
         end
         S_RANGE: begin
            if (zero) begin
               range_in = '0;
            end else if (rng_full > RNG_W'(16'hFFFF)) begin
               range_in = 16'hFFFF;
            end else begin
               range_in = rng_full[15:0];
            end
            travel_in = ppsh_pkg::wrap_turn(t_diff);
            state_in  = S_PROD;
         end
         S_PROD: begin
            p1_in    = 40'(cfg.distance_gain) * 40'(range_ff);
            p2_in    = 42'(r_diff) * 42'(ag_s);
            last_in  = range_ff;
            state_in = S_SUM;
         end
         S_SUM: begin
            if (spd > $signed({18'b0, cfg.speed_ceiling})) begin
               res_in.drive_speed = {1'b0, cfg.speed_ceiling};
            end else if (spd < -33'sd32768) begin
               res_in.drive_speed = 16'h8000;
            end else begin
               res_in.drive_speed = spd[15:0];
            end
            res_in.travel_angle  = travel_ff;
            res_in.range_to_goal = range_ff;
            state_in = S_HOLD;
         end
         S_HOLD: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         last_ff  <= '0;
      end else begin
         state_ff <= state_in;
         last_ff  <= last_in;
      end
      mag_ff    <= mag_in;
      acc_ff    <= acc_in;
      cnt_ff    <= cnt_in;
      bear_ff   <= bear_in;
      range_ff  <= range_in;
      travel_ff <= travel_in;
      p1_ff     <= p1_in;
      p2_ff     <= p2_in;
      res_ff    <= res_in;
   end

   assign res_valid = (state_ff == S_HOLD);
   assign res       = res_ff;

endmodule

FILE: rtl/pose_pursuit_speed_heading_top.sv
`timescale 1ns / 1ps
// Point-to-point pursuit controller. Each request item carries goal and current position plus
// current and desired heading; one response item follows with speed (q1.15, capped at
// speed_ceiling and at -1.0), the goal bearing relative to the heading and the wrapped desired
// heading (both centidegrees, 0..35999), the smoothing constant and the range to the goal.
// Bearing and range come from a row of CORDIC_STEPS vectoring cells, one rotation per cell and
// cycle; the range is then scaled by a 16-bit-digit multiplier and the speed formed in the
// range, product and sum states. One item is in flight at a time, from acceptance to a valid
// response; a new item is taken while the previous response waits.
// The previous range is kept for the approach term and starts at zero after reset.
module pose_pursuit_speed_heading_top #(
   parameter int COORD_WIDTH  = ppsh_pkg::COORD_WIDTH_DEF,
   parameter int CORDIC_STEPS = ppsh_pkg::CORDIC_STEPS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // goal_x, goal_y, here_x, here_y, here_heading, goal_heading, zero fill
   input  logic [ppsh_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // drive_speed, travel_angle, facing_angle, smoothing_out, range_to_goal
   output logic [ppsh_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                               csr_we,
   input  logic [ppsh_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [ppsh_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int DATA_W = COORD_WIDTH + ppsh_pkg::CORD_GUARD;

   logic [23:0] dg_ff, dg_in;
   logic [23:0] ag_ff, ag_in;
   logic [14:0] ceil_ff, ceil_in;
   logic [23:0] smooth_ff, smooth_in;

   logic        busy_ff, busy_in;
   logic        zero_ff, zero_in;
   logic [15:0] head_ff, head_in;
   logic [15:0] facing_ff, facing_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [ppsh_pkg::RSP_DATA_W-1:0]    rsp_data_ff, rsp_data_in;

   logic [COORD_WIDTH-1:0]             gx_w, gy_w, hx_w, hy_w;
   logic signed [COORD_WIDTH:0]        dx, dy;
   logic                               accept, take;
   logic                               cord_done;
   logic signed [DATA_W-1:0]           cord_a;
   logic signed [ppsh_pkg::Z_W-1:0]    cord_z;
   logic                               res_valid;
   ppsh_pkg::res_type                  res;
   ppsh_pkg::cfg_type                  cfg;

   assign accept = req_tvalid && req_tready;
   assign take   = res_valid && (!rsp_valid_ff || rsp_tready);

   assign gx_w = COORD_WIDTH'(req_tdata[15:0]);
   assign gy_w = COORD_WIDTH'(req_tdata[31:16]);
   assign hx_w = COORD_WIDTH'(req_tdata[47:32]);
   assign hy_w = COORD_WIDTH'(req_tdata[63:48]);
   assign dx = $signed({gx_w[COORD_WIDTH-1], gx_w}) - $signed({hx_w[COORD_WIDTH-1], hx_w});
   assign dy = $signed({gy_w[COORD_WIDTH-1], gy_w}) - $signed({hy_w[COORD_WIDTH-1], hy_w});

   always_comb begin
      dg_in     = dg_ff;
      ag_in     = ag_ff;
      ceil_in   = ceil_ff;
      smooth_in = smooth_ff;
      if (csr_we) begin
         case (csr_addr)
            ppsh_pkg::REG_DISTANCE_GAIN:      dg_in     = csr_wdata;
            ppsh_pkg::REG_APPROACH_RATE_GAIN: ag_in     = csr_wdata;
            ppsh_pkg::REG_SPEED_CEILING:      ceil_in   = csr_wdata[14:0];
            ppsh_pkg::REG_SMOOTHING_CONSTANT: smooth_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      busy_in   = busy_ff;
      zero_in   = zero_ff;
      head_in   = head_ff;
      facing_in = facing_ff;
      if (accept) begin
         busy_in   = 1'b1;
         zero_in   = (dx == '0) && (dy == '0);
         head_in   = req_tdata[79:64];
         facing_in = ppsh_pkg::wrap_turn($signed({req_tdata[97], req_tdata[97:80]}));
      end else if (take) begin
         busy_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {res.range_to_goal, smooth_ff, facing_ff,
                         res.travel_angle, res.drive_speed};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dg_ff        <= ppsh_pkg::DISTANCE_GAIN_RST;
         ag_ff        <= ppsh_pkg::APPROACH_RATE_GAIN_RST;
         ceil_ff      <= ppsh_pkg::SPEED_CEILING_RST;
         smooth_ff    <= ppsh_pkg::SMOOTHING_CONSTANT_RST;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         dg_ff        <= dg_in;
         ag_ff        <= ag_in;
         ceil_ff      <= ceil_in;
         smooth_ff    <= smooth_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      zero_ff     <= zero_in;
      head_ff     <= head_in;
      facing_ff   <= facing_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign cfg.distance_gain      = dg_ff;
   assign cfg.approach_rate_gain = ag_ff;
   assign cfg.speed_ceiling      = ceil_ff;

   ppsh_cordic #(
      .COORD_WIDTH  (COORD_WIDTH),
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .dx    (dx),
      .dy    (dy),
      .done  (cord_done),
      .a_out (cord_a),
      .z_out (cord_z)
   );

   ppsh_scale #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_scale (
      .clock     (clock),
      .reset     (reset),
      .start     (cord_done),
      .cord_a    (cord_a),
      .cord_z    (cord_z),
      .zero      (zero_ff),
      .heading   (head_ff),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res_take  (take),
      .res       (res)
   );

   assign req_tready = !busy_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: rtl/ppsh_checker.sv
`timescale 1ns / 1ps
module ppsh_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [ppsh_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   // one item in flight
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while an item is in flight");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("reset did not clear the channels");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("response without an item in flight");

   a_angles_wrapped: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[31:16] < ppsh_pkg::FULL_TURN) &&
                     (rsp_tdata[47:32] < ppsh_pkg::FULL_TURN))
      else $error("angle out of range");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

endmodule

bind pose_pursuit_speed_heading_top ppsh_checker u_ppsh_checker (.*);

FILE: bench/pose_pursuit_speed_heading_top_test.sv
`timescale 1ns / 1ps
module pose_pursuit_speed_heading_top_test;

   localparam int  TURN_CENTIDEG = 36000;
   localparam int  MAX_GAP       = 11;
   localparam int  ITEMS_PER_SET = 160;
   localparam int  SETTING_COUNT = 8;
   localparam int  CYCLE_LIMIT   = 400000;
   localparam int  TAIL_CYCLES   = 40;

   // atan(2^-i) in centidegrees, q16
   localparam longint CORDIC_ANGLE [16] = '{
      294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
      5866610, 2933484, 1466765, 733385, 366693, 183347,
      91674, 45837, 22918, 11459
   };

   typedef enum logic [1:0] {OP_ITEM, OP_WRITE, OP_DRAIN} op_kind_type;

   typedef struct {
      op_kind_type kind;
      logic [15:0] goal_x;
      logic [15:0] goal_y;
      logic [15:0] here_x;
      logic [15:0] here_y;
      logic [15:0] here_heading;
      logic [17:0] goal_heading;
      logic [ppsh_pkg::CSR_ADDR_W-1:0] reg_index;
      logic [ppsh_pkg::CSR_DATA_W-1:0] reg_value;
   } pursuit_op_type;

   typedef struct packed {
      logic [15:0] drive_speed;
      logic [15:0] travel_angle;
      logic [15:0] facing_angle;
      logic [23:0] smoothing_out;
      logic [15:0] range_to_goal;
   } pursuit_result_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [ppsh_pkg::REQ_DATA_W-1:0]     req_tdata = '0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [ppsh_pkg::RSP_DATA_W-1:0]     rsp_tdata;
   logic                                csr_we = 1'b0;
   logic [ppsh_pkg::CSR_ADDR_W-1:0]     csr_addr = '0;
   logic [ppsh_pkg::CSR_DATA_W-1:0]     csr_wdata = '0;

   pursuit_op_type     pending_ops [$];
   pursuit_result_type expected_results [$];

   logic [23:0] gain_distance;
   logic [23:0] gain_approach;
   logic [14:0] speed_limit;
   logic [23:0] smoothing_value;
   logic [15:0] prev_range;

   logic   req_taken = 1'b0;
   logic   rsp_taken = 1'b0;
   int     send_gap = 0;
   int     recv_stall = 0;
   bit     send_calm = 1'b0;
   bit     recv_calm = 1'b0;
   int     mismatch_count = 0;
   int     cycle_count = 0;

   pose_pursuit_speed_heading_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic logic [15:0] wrap_centideg(input longint v);
      longint r;
      r = v % TURN_CENTIDEG;
      if (r < 0) begin
         r = r + TURN_CENTIDEG;
      end
      return r[15:0];
   endfunction

   // bearing and range by cordic vectoring, then the speed law; updates prev_range
   function automatic pursuit_result_type predict_pursuit(
      input logic [ppsh_pkg::REQ_DATA_W-1:0] d
   );
      longint             dx, dy, hdg, ghdg, a, b, a0, z, bearing, rng, s, spd;
      longint unsigned    prod;
      int                 i;
      pursuit_result_type r;
      dx = longint'($signed(d[15:0])) - longint'($signed(d[47:32]));
      dy = longint'($signed(d[31:16])) - longint'($signed(d[63:48]));
      hdg = longint'(d[79:64]);
      ghdg = longint'($signed(d[97:80]));
      bearing = 0;
      rng = 0;
      if (dx != 0 || dy != 0) begin
         a = dy * 65536;
         b = dx * 65536;
         z = 0;
         if (a < 0) begin
            a = -a;
            b = -b;
            z = 64'sd18000 * 64'sd65536;
         end
         for (i = 0; i < 16; i++) begin
            a0 = a;
            if (b > 0) begin
               a = a + (b >>> i);
               b = b - (a0 >>> i);
               z = z + CORDIC_ANGLE[i];
            end else begin
               a = a - (b >>> i);
               b = b + (a0 >>> i);
               z = z - CORDIC_ANGLE[i];
            end
         end
         bearing = longint'(wrap_centideg((z + 32768) >>> 16));
         if (a < 0) begin
            a = 0;
         end
         prod = ($unsigned(a) * 64'd652032874 + (64'd1 << 45)) >> 46;
         rng = (prod > 64'd65535) ? 65535 : longint'(prod);
      end
      s = longint'(gain_distance) * rng
        + longint'(gain_approach) * (rng - longint'(prev_range));
      spd = (s + 256) >>> 9;
      if (spd > longint'(speed_limit)) begin
         spd = longint'(speed_limit);
      end
      if (spd < -32768) begin
         spd = -32768;
      end
      r.drive_speed   = spd[15:0];
      r.travel_angle  = wrap_centideg(bearing - hdg);
      r.facing_angle  = wrap_centideg(ghdg);
      r.smoothing_out = smoothing_value;
      r.range_to_goal = rng[15:0];
      prev_range = rng[15:0];
      return r;
   endfunction

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   task automatic add_item(input int gx, input int gy, input int hx, input int hy,
                           input int hh, input int gh);
      pursuit_op_type op;
      op = '{kind: OP_ITEM, default: '0};
      op.goal_x = gx[15:0];
      op.goal_y = gy[15:0];
      op.here_x = hx[15:0];
      op.here_y = hy[15:0];
      op.here_heading = hh[15:0];
      op.goal_heading = gh[17:0];
      pending_ops.push_back(op);
   endtask

   task automatic add_drain();
      pursuit_op_type op;
      op = '{kind: OP_DRAIN, default: '0};
      pending_ops.push_back(op);
   endtask

   task automatic add_write(input logic [ppsh_pkg::CSR_ADDR_W-1:0] idx,
                            input logic [23:0] value);
      pursuit_op_type op;
      op = '{kind: OP_WRITE, default: '0};
      op.reg_index = idx;
      op.reg_value = value;
      pending_ops.push_back(op);
   endtask

   task automatic add_setting(input logic [23:0] dg, input logic [23:0] ag,
                              input logic [23:0] ceil_val, input logic [23:0] sm);
      add_drain();
      add_write(ppsh_pkg::REG_DISTANCE_GAIN, dg);
      add_write(ppsh_pkg::REG_APPROACH_RATE_GAIN, ag);
      add_write(ppsh_pkg::REG_SPEED_CEILING, ceil_val);
      add_write(ppsh_pkg::REG_SMOOTHING_CONSTANT, sm);
   endtask

   task automatic add_random_item();
      int kind, hx, hy, gx, gy, hh, gh;
      kind = $urandom_range(0, 9);
      hx = int'($urandom_range(0, 64000)) - 32000;
      hy = int'($urandom_range(0, 64000)) - 32000;
      case (kind)
         0, 1: begin
            gx = $urandom;
            gy = $urandom;
            hx = $urandom;
            hy = $urandom;
         end
         2, 3, 4, 5: begin
            gx = hx + int'($urandom_range(0, 1000)) - 500;
            gy = hy + int'($urandom_range(0, 1000)) - 500;
         end
         6: begin
            gx = hx;
            gy = hy;
         end
         7: begin
            gx = hx;
            gy = hy;
            if ($urandom_range(0, 1) == 0) begin
               gx = hx + int'($urandom_range(0, 1000)) - 500;
            end else begin
               gy = hy + int'($urandom_range(0, 1000)) - 500;
            end
         end
         default: begin
            gx = hx + int'($urandom_range(0, 40)) - 20;
            gy = hy + int'($urandom_range(0, 40)) - 20;
         end
      endcase
      hh = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 35999);
      gh = ($urandom_range(0, 15) == 0) ? int'($urandom_range(0, 262143)) - 131072
                                        : int'($urandom_range(0, 107999)) - 36000;
      add_item(gx, gy, hx, hy, hh, gh);
   endtask

   always @(posedge clock) begin
      pursuit_result_type want, got;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
      if (reset) begin
         gain_distance = ppsh_pkg::DISTANCE_GAIN_RST;
         gain_approach = ppsh_pkg::APPROACH_RATE_GAIN_RST;
         speed_limit = ppsh_pkg::SPEED_CEILING_RST;
         smoothing_value = ppsh_pkg::SMOOTHING_CONSTANT_RST;
         prev_range = '0;
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         rsp_taken <= rsp_tvalid && rsp_tready;
         if (csr_we) begin
            case (csr_addr)
               ppsh_pkg::REG_DISTANCE_GAIN:      gain_distance = csr_wdata;
               ppsh_pkg::REG_APPROACH_RATE_GAIN: gain_approach = csr_wdata;
               ppsh_pkg::REG_SPEED_CEILING:      speed_limit = csr_wdata[14:0];
               ppsh_pkg::REG_SMOOTHING_CONSTANT: smoothing_value = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            expected_results.push_back(predict_pursuit(req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            got.drive_speed   = rsp_tdata[15:0];
            got.travel_angle  = rsp_tdata[31:16];
            got.facing_angle  = rsp_tdata[47:32];
            got.smoothing_out = rsp_tdata[71:48];
            got.range_to_goal = rsp_tdata[87:72];
            if (expected_results.size() == 0) begin
               $error("result item with none expected: %h", rsp_tdata);
               mismatch_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("drive_speed", longint'($signed(want.drive_speed)),
                           longint'($signed(got.drive_speed)));
               check_field("travel_angle", longint'(want.travel_angle),
                           longint'(got.travel_angle));
               check_field("facing_angle", longint'(want.facing_angle),
                           longint'(got.facing_angle));
               check_field("smoothing_out", longint'(want.smoothing_out),
                           longint'(got.smoothing_out));
               check_field("range_to_goal", longint'(want.range_to_goal),
                           longint'(got.range_to_goal));
            end
         end
      end
   end

   always @(negedge clock) begin
      logic           nxt_valid;
      logic           nxt_we;
      pursuit_op_type op;
      nxt_valid = req_tvalid;
      nxt_we = 1'b0;
      if (!reset) begin
         if (req_tvalid && req_taken) begin
            nxt_valid = 1'b0;
         end
         if (!nxt_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_ops.size() > 0) begin
               case (pending_ops[0].kind)
                  OP_ITEM: begin
                     op = pending_ops.pop_front();
                     req_tdata <= {6'b0, op.goal_heading, op.here_heading, op.here_y,
                                   op.here_x, op.goal_y, op.goal_x};
                     nxt_valid = 1'b1;
                     if ($urandom_range(0, 39) == 0) begin
                        send_calm = !send_calm;
                     end
                     send_gap = send_calm ? 0 : $urandom_range(0, MAX_GAP);
                  end
                  OP_WRITE: begin
                     if (expected_results.size() == 0 && !req_tvalid) begin
                        op = pending_ops.pop_front();
                        nxt_we = 1'b1;
                        csr_addr <= op.reg_index;
                        csr_wdata <= op.reg_value;
                     end
                  end
                  default: begin
                     if (expected_results.size() == 0 && !req_tvalid) begin
                        void'(pending_ops.pop_front());
                     end
                  end
               endcase
            end
         end
      end
      req_tvalid <= nxt_valid;
      csr_we <= nxt_we;
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_taken) begin
            if ($urandom_range(0, 39) == 0) begin
               recv_calm = !recv_calm;
            end
            recv_stall = recv_calm ? 0 : $urandom_range(0, MAX_GAP);
         end
         rsp_tready <= (recv_stall == 0);
         if (rsp_tvalid && recv_stall > 0) begin
            recv_stall--;
         end
      end
   end

   initial begin
      int n, s;
      // coincident points, extremes, axes and heading wrap at reset gains
      add_item(0, 0, 0, 0, 0, 0);
      add_item(1234, -5678, 1234, -5678, 9000, 4500);
      add_item(32767, 32767, -32768, -32768, 0, 0);
      add_item(-32768, -32768, 32767, 32767, 65535, -131072);
      add_item(0, 0, 0, 0, 35999, 71999);
      add_item(100, 0, 0, 0, 0, 0);
      add_item(-100, 0, 0, 0, 0, 0);
      add_item(0, 100, 0, 0, 0, 0);
      add_item(0, -100, 0, 0, 0, 0);
      add_item(-32768, 0, 32767, 0, 100, -36000);
      add_item(0, -32768, 0, 32767, 200, 36000);
      add_item(3, 4, 0, 0, 35999, 71999);
      add_item(-3, -4, 0, 0, 36000, -36000);
      add_item(10, -7, 0, 0, 18000, 131071);
      add_item(-10, 7, 0, 0, 1, -1);
      add_item(1, 1, 0, 0, 0, 36000);
      add_item(-1, 0, 0, 0, 0, 35999);
      add_item(0, 1, 0, 0, 0, 72000);
      add_item(0, 0, 0, 0, 0, 0);
      for (s = 0; s < SETTING_COUNT; s++) begin
         case (s)
            0: add_setting(24'h0, 24'h0, 24'h0, 24'h0);
            1: add_setting(24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff);
            2: add_setting(ppsh_pkg::DISTANCE_GAIN_RST, ppsh_pkg::APPROACH_RATE_GAIN_RST,
                           24'(ppsh_pkg::SPEED_CEILING_RST),
                           ppsh_pkg::SMOOTHING_CONSTANT_RST);
            3: add_setting(24'($urandom_range(0, 4095)), 24'($urandom_range(0, 4095)),
                           24'h007fff, 24'($urandom));
            default: add_setting(24'($urandom_range(0, 65535)),
                                 24'($urandom_range(0, 65535)),
                                 24'($urandom), 24'($urandom));
         endcase
         for (n = 0; n < ITEMS_PER_SET; n++) begin
            if ($urandom_range(0, 59) == 0) begin
               add_drain();
            end
            add_random_item();
         end
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (pending_ops.size() != 0 || req_tvalid || expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/ppsh_pkg.sv
rtl/ppsh_cell.sv
rtl/ppsh_cordic.sv
rtl/ppsh_scale.sv
rtl/pose_pursuit_speed_heading_top.sv
rtl/ppsh_checker.sv
bench/pose_pursuit_speed_heading_top_test.sv
